// File: src/bls_pkg.sv
package bls_pkg;

   localparam int COLOR_BITS = 16;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_NEXT = 1'b1
   } kind_type;

endpackage

// File: src/bresenham_line_stepper.sv
// Channel   Ports                                   Direction  Handshake
// request   req_kind, req_start_*, req_end_*        in         req_valid / req_stall
// response  rsp_pixel_*, rsp_valid_res, rsp_last    out        rsp_valid / rsp_stall
// csr       csr_wr_data (front color)               in         csr_wr_en
//
// One request per clock while req_stall is low. Each request gives exactly one response.
// The response comes from an output register backed by one skid entry.
// The request side stalls only while the skid entry is full.
// Line state is updated when a request is accepted, not when its response leaves.
// Reset (synchronous, active high) ends any line and clears the color and the
// response queue.
module bresenham_line_stepper #(
   parameter int COORD_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [COORD_BITS-1:0]           req_start_x,
   input  logic [COORD_BITS-1:0]           req_start_y,
   input  logic [COORD_BITS-1:0]           req_end_x,
   input  logic [COORD_BITS-1:0]           req_end_y,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COORD_BITS-1:0]           rsp_pixel_x,
   output logic [COORD_BITS-1:0]           rsp_pixel_y,
   output logic [bls_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                            rsp_valid_res,
   output logic                            rsp_last,

   input  logic                            csr_wr_en,
   input  logic [bls_pkg::COLOR_BITS-1:0]  csr_wr_data
);

   localparam int EW = COORD_BITS + 3;

   typedef struct packed {
      logic [COORD_BITS-1:0]          pixel_x;
      logic [COORD_BITS-1:0]          pixel_y;
      logic [bls_pkg::COLOR_BITS-1:0] pixel_color;
      logic                           valid_res;
      logic                           last;
   } rsp_type;

   logic [bls_pkg::COLOR_BITS-1:0] front_color_ff;

   logic                  active_ff,          active_in;
   logic                  steep_ff,           steep_in;
   logic [COORD_BITS-1:0] major_pos_ff,       major_pos_in;
   logic [COORD_BITS-1:0] minor_pos_ff,       minor_pos_in;
   logic [COORD_BITS-1:0] major_end_ff,       major_end_in;
   logic signed [EW-1:0]  error_ff,           error_in;
   logic [COORD_BITS:0]   twice_major_ff,     twice_major_in;
   logic [COORD_BITS:0]   twice_minor_ff,     twice_minor_in;
   logic                  step_down_ff,       step_down_in;

   rsp_type rsp_ff,  rsp_in;
   rsp_type skid_ff;
   logic    rsp_valid_ff;
   logic    skid_valid_ff;

   logic req_accept;
   logic rsp_take;
   logic is_load;

   // load-side geometry
   logic [COORD_BITS-1:0] dx_abs, dy_abs;
   logic                  ld_steep, ld_swap;
   logic [COORD_BITS-1:0] a0, a1, b0, b1;
   logic [COORD_BITS-1:0] ld_major, ld_minor, ld_major_end, ld_minor_end;
   logic [COORD_BITS-1:0] ld_major_delta, ld_minor_delta;

   // state seen by this request
   logic                  cur_steep;
   logic [COORD_BITS-1:0] cur_major, cur_minor, cur_major_end;
   logic signed [EW-1:0]  cur_error;
   logic [COORD_BITS:0]   cur_twice_major, cur_twice_minor;
   logic                  cur_step_down;
   logic                  cur_last;
   logic signed [EW-1:0]  err_add;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign is_load    = (bls_pkg::kind_type'(req_kind) == bls_pkg::KIND_LOAD);

   always_comb begin
      dx_abs = (req_end_x > req_start_x) ? req_end_x - req_start_x
                                         : req_start_x - req_end_x;
      dy_abs = (req_end_y > req_start_y) ? req_end_y - req_start_y
                                         : req_start_y - req_end_y;
      ld_steep = dy_abs > dx_abs;
      a0 = ld_steep ? req_start_y : req_start_x;
      b0 = ld_steep ? req_start_x : req_start_y;
      a1 = ld_steep ? req_end_y   : req_end_x;
      b1 = ld_steep ? req_end_x   : req_end_y;
      ld_swap      = a0 > a1;
      ld_major     = ld_swap ? a1 : a0;
      ld_minor     = ld_swap ? b1 : b0;
      ld_major_end = ld_swap ? a0 : a1;
      ld_minor_end = ld_swap ? b0 : b1;
      // endpoint swap does not change the extents
      ld_major_delta = ld_steep ? dy_abs : dx_abs;
      ld_minor_delta = ld_steep ? dx_abs : dy_abs;
   end

   always_comb begin
      if (is_load) begin
         cur_steep       = ld_steep;
         cur_major       = ld_major;
         cur_minor       = ld_minor;
         cur_major_end   = ld_major_end;
         cur_error       = -$signed({3'b000, ld_major_delta});
         cur_twice_major = {ld_major_delta, 1'b0};
         cur_twice_minor = {ld_minor_delta, 1'b0};
         cur_step_down   = !(ld_minor < ld_minor_end);
      end else begin
         cur_steep       = steep_ff;
         cur_major       = major_pos_ff;
         cur_minor       = minor_pos_ff;
         cur_major_end   = major_end_ff;
         cur_error       = error_ff;
         cur_twice_major = twice_major_ff;
         cur_twice_minor = twice_minor_ff;
         cur_step_down   = step_down_ff;
      end
      cur_last = (cur_major == cur_major_end);
      err_add  = cur_error + $signed({2'b00, cur_twice_minor});
   end

   always_comb begin
      active_in      = active_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      error_in       = error_ff;
      twice_major_in = twice_major_ff;
      twice_minor_in = twice_minor_ff;
      step_down_in   = step_down_ff;

      rsp_in = '0;

      if (req_accept && (is_load || active_ff)) begin
         steep_in       = cur_steep;
         major_end_in   = cur_major_end;
         twice_major_in = cur_twice_major;
         twice_minor_in = cur_twice_minor;
         step_down_in   = cur_step_down;
         major_pos_in   = cur_major;
         minor_pos_in   = cur_minor;
         error_in       = cur_error;
         active_in      = !cur_last;
         if (!cur_last) begin
            major_pos_in = cur_major + 1'b1;
            error_in     = err_add;
            // tie at zero steps the minor axis
            if (!err_add[EW-1]) begin
               minor_pos_in = cur_step_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
               error_in     = err_add - $signed({2'b00, cur_twice_major});
            end
         end

         rsp_in.pixel_x     = cur_steep ? cur_minor : cur_major;
         rsp_in.pixel_y     = cur_steep ? cur_major : cur_minor;
         rsp_in.pixel_color = front_color_ff;
         rsp_in.valid_res   = 1'b1;
         rsp_in.last        = cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_color_ff <= '0;
         active_ff      <= 1'b0;
         steep_ff       <= 1'b0;
         major_pos_ff   <= '0;
         minor_pos_ff   <= '0;
         major_end_ff   <= '0;
         error_ff       <= '0;
         twice_major_ff <= '0;
         twice_minor_ff <= '0;
         step_down_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            front_color_ff <= csr_wr_data;
         end
         active_ff      <= active_in;
         steep_ff       <= steep_in;
         major_pos_ff   <= major_pos_in;
         minor_pos_ff   <= minor_pos_in;
         major_end_ff   <= major_end_in;
         error_ff       <= error_in;
         twice_major_ff <= twice_major_in;
         twice_minor_ff <= twice_minor_in;
         step_down_ff   <= step_down_in;
      end
   end

   // output register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= rsp_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_ff.pixel_x;
   assign rsp_pixel_y     = rsp_ff.pixel_y;
   assign rsp_pixel_color = rsp_ff.pixel_color;
   assign rsp_valid_res   = rsp_ff.valid_res;
   assign rsp_last        = rsp_ff.last;

`ifndef SYNTH
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full while output register empty");

   a_error_negative: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> error_ff[EW-1])
      else $error("error term not negative between pixels");

   a_major_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (major_pos_ff <= major_end_ff))
      else $error("major position ran past line end");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (is_load || active_ff) && cur_last) |=> !active_ff)
      else $error("line still active after last pixel");
`endif

endmodule
